>>> rtl/core/hbdt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbdt_pkg
// Shared types and constants of the H-bridge drive dead-time unit.
// ----------------------------------------------------------------------------
package hbdt_pkg;

    localparam int DUTY_W   = 13;
    localparam int CMD_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int OUT_TDATA_W = 32;
    localparam int Q_DEPTH  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_LIMIT = 2'd1;

    localparam logic [DUTY_W-1:0] CURRENT_LIMIT_RESET = 13'd4500;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        KIND_ZERO   = 2'd0,
        KIND_SAME   = 2'd1,
        KIND_CHANGE = 2'd2
    } t_kind;

    // one classified command waiting for the back end
    typedef struct packed {
        t_kind             kind;
        logic              rev;
        logic [DUTY_W-1:0] mag;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage : hbdt_pkg
`default_nettype wire

>>> rtl/core/hbdt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbdt_front
// Accepts drive commands, applies enable and clamp, classifies the command
// against the previous direction and pushes it into the queue.
// ----------------------------------------------------------------------------
module hbdt_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [hbdt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [hbdt_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                            i_cmd_valid,
    input  wire logic [hbdt_pkg::CMD_W-1:0]      i_cmd,
    input  wire hbdt_pkg::t_q_flags              i_q_flags,
    output logic                                 o_cmd_ready,
    output logic                                 o_push,
    output hbdt_pkg::t_entry                     o_entry
);
    import hbdt_pkg::*;

    logic              r_enable, n_enable;
    logic [DUTY_W-1:0] r_max, n_max;
    t_dir              r_prev_dir, n_prev_dir;

    logic              neg;
    logic [CMD_W:0]    mag_full;
    logic [DUTY_W-1:0] mag;
    t_dir              dir;
    logic              accept;

    assign o_cmd_ready = !i_q_flags.full;
    assign accept      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        neg      = i_cmd[CMD_W-1];
        mag_full = neg ? ((CMD_W+1)'(1) << CMD_W) - {1'b0, i_cmd} : {1'b0, i_cmd};
        if (!r_enable) begin
            mag_full = '0;
        end
        if (mag_full > {{(CMD_W+1-DUTY_W){1'b0}}, r_max}) begin
            mag = r_max;
        end else begin
            mag = mag_full[DUTY_W-1:0];
        end
        dir = neg ? DIR_REV : DIR_FWD;

        o_entry.mag = mag;
        o_entry.rev = neg;
        n_prev_dir  = r_prev_dir;
        if (mag == '0) begin
            o_entry.kind = KIND_ZERO;
            n_prev_dir   = DIR_STOP;
        end else if (dir == r_prev_dir) begin
            o_entry.kind = KIND_SAME;
        end else begin
            o_entry.kind = KIND_CHANGE;
            n_prev_dir   = dir;
        end
        o_push = accept;
    end

    always_comb begin
        n_enable = r_enable;
        n_max    = r_max;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DRIVE_ENABLE:  n_enable = i_cfg_data[0];
                CFG_CURRENT_LIMIT: n_max    = i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_max      <= CURRENT_LIMIT_RESET;
            r_prev_dir <= DIR_STOP;
        end else begin
            r_enable <= n_enable;
            r_max    <= n_max;
            if (accept) begin
                r_prev_dir <= n_prev_dir;
            end
        end
    end

endmodule : hbdt_front
`default_nettype wire

>>> rtl/core/hbdt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbdt_queue
// Short register queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module hbdt_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hbdt_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output hbdt_pkg::t_entry       o_head,
    output hbdt_pkg::t_q_flags     o_flags
);
    import hbdt_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_flags.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);
    assign do_push = i_push && !o_flags.full;
    assign do_pop  = i_pop && !o_flags.empty;
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(Q_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : hbdt_queue
`default_nettype wire

>>> rtl/core/hbdt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbdt_back
// Walks each queued command through its pin-state steps, holds the bridge
// pin state and drives the registered result stream.
// ----------------------------------------------------------------------------
module hbdt_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire hbdt_pkg::t_entry                   i_head,
    input  wire hbdt_pkg::t_q_flags                 i_q_flags,
    output logic                                    o_pop,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output logic [hbdt_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tlast
);
    import hbdt_pkg::*;

    logic [DUTY_W-1:0] r_fwd, n_fwd, r_rev, n_rev;
    logic              r_left, n_left, r_right, n_right;
    logic [1:0]        r_step;
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_out_fwd, r_out_rev;
    logic              r_out_left, r_out_right, r_out_settle, r_out_last;
    logic              advance, last;

    assign advance = (!r_out_valid || i_m_axis_tready) && !i_q_flags.empty;
    assign o_pop   = advance && last;

    always_comb begin
        n_fwd   = r_fwd;
        n_rev   = r_rev;
        n_left  = r_left;
        n_right = r_right;
        last    = 1'b1;
        unique case (i_head.kind)
            KIND_SAME: begin
                n_left  = i_head.rev;
                n_right = !i_head.rev;
                if (i_head.rev) begin
                    n_rev = i_head.mag;
                end else begin
                    n_fwd = i_head.mag;
                end
            end
            KIND_CHANGE: begin
                last = (r_step == 2'd3);
                unique case (r_step)
                    2'd0: begin
                        // clear the opposite compare
                        if (i_head.rev) n_fwd = '0;
                        else            n_rev = '0;
                    end
                    2'd1: begin
                        if (i_head.rev) n_right = 1'b0;
                        else            n_left  = 1'b0;
                    end
                    2'd2: begin
                        if (i_head.rev) n_left  = 1'b1;
                        else            n_right = 1'b1;
                    end
                    default: begin
                        if (i_head.rev) n_rev = i_head.mag;
                        else            n_fwd = i_head.mag;
                    end
                endcase
            end
            default: begin
                n_fwd   = '0;
                n_rev   = '0;
                n_left  = 1'b0;
                n_right = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd       <= '0;
            r_rev       <= '0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_fwd       <= n_fwd;
                r_rev       <= n_rev;
                r_left      <= n_left;
                r_right     <= n_right;
                r_step      <= last ? 2'd0 : r_step + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_fwd    <= n_fwd;
            r_out_rev    <= n_rev;
            r_out_left   <= n_left;
            r_out_right  <= n_right;
            r_out_settle <= !last;
            r_out_last   <= last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 2*DUTY_W - 3){1'b0}},
                              r_out_settle, r_out_right, r_out_left,
                              r_out_rev, r_out_fwd};

endmodule : hbdt_back
`default_nettype wire

>>> rtl/core/h_bridge_drive_dead_time_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// h_bridge_drive_dead_time_unit
// H-bridge direction and duty control with dead-time ordered pin states.
// ----------------------------------------------------------------------------
// path: accepted commands pass the queue, then the back end's output register
// throughput: one result per cycle from the output register when not stalled;
//   direction changes and starts give clear, open, close and set-duty steps
// reset: synchronous active low; both compares 0, both low sides off,
//   stopped, drive disabled, current limit 4500, queue and output emptied
module h_bridge_drive_dead_time_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [hbdt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [hbdt_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // command stream
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  wire logic [hbdt_pkg::CMD_W-1:0]         i_s_axis_tdata,  // drive_command
    // pin-state stream
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // forward_compare, reverse_compare, left_low_en, right_low_en, settle_after
    output logic [hbdt_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    output logic                                    o_m_axis_tlast   // last_of_run
);
    import hbdt_pkg::*;

    t_entry   push_entry, head;
    t_q_flags q_flags;
    logic     push, pop;

    assign o_cfg_ready = 1'b1;

    hbdt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (i_s_axis_tvalid),
        .i_cmd       (i_s_axis_tdata),
        .i_q_flags   (q_flags),
        .o_cmd_ready (o_s_axis_tready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    hbdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (q_flags)
    );

    hbdt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_flags       (q_flags),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule : h_bridge_drive_dead_time_unit
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the H-bridge drive dead-time unit. Drive commands
// are streamed in from a queue while a behavioral predictor works out the pin
// states each accepted request must produce. A monitor compares every pin
// state field by field, in order, against those predictions. Settings of
// drive enable and current limit change between phases, and both stream
// sides stall at random. One phase holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

    import hbdt_pkg::*;

    localparam int  HOLD_CYCLES = 400;
    localparam real TIMEOUT_NS  = 2_000_000.0;

    // one pin state as the bridge should show it
    typedef struct packed {
        logic [DUTY_W-1:0] fwd_cmp;
        logic [DUTY_W-1:0] rev_cmp;
        logic              left_on;
        logic              right_on;
        logic              settle;
        logic              last;
    } t_pin_state;

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index     = CFG_DRIVE_ENABLE;
    logic [CFG_DAT_W-1:0]     i_cfg_data      = '0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic [CMD_W-1:0]         i_s_axis_tdata  = '0;
    logic                     i_m_axis_tready = 1'b0;
    logic                     o_cfg_ready;
    logic                     o_s_axis_tready;
    logic                     o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0]   o_m_axis_tdata;
    logic                     o_m_axis_tlast;

    // predictor copy of the bridge state and its settings
    logic                     cfg_drive_enable  = 1'b0;
    logic [DUTY_W-1:0]        cfg_current_limit = CURRENT_LIMIT_RESET;
    logic [DUTY_W-1:0]        fwd_duty         = '0;
    logic [DUTY_W-1:0]        rev_duty         = '0;
    logic                     left_on          = 1'b0;
    logic                     right_on         = 1'b0;
    t_dir                     last_dir         = DIR_STOP;

    logic [CMD_W-1:0]         drive_cmd_queue[$];
    t_pin_state               expected_pin_states[$];

    int                       send_idle_pct    = 0;
    int                       recv_idle_pct    = 0;
    logic                     hold_go          = 1'b0;
    logic                     hold_off         = 1'b0;
    int                       run_left         = 0;
    logic                     run_neg          = 1'b0;

    int                       errors           = 0;
    int                       cmds_accepted    = 0;
    int                       dir_changes      = 0;
    int                       pin_states_seen  = 0;

    h_bridge_drive_dead_time_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void push_pin_state(input logic settle, input logic last);
        t_pin_state ps;
        ps.fwd_cmp  = fwd_duty;
        ps.rev_cmp  = rev_duty;
        ps.left_on  = left_on;
        ps.right_on = right_on;
        ps.settle   = settle;
        ps.last     = last;
        expected_pin_states.push_back(ps);
    endfunction

    // pin states caused by one accepted drive command
    task automatic predict_pin_states(input logic [CMD_W-1:0] cmd);
        logic        neg;
        logic [16:0] mag;
        t_dir        dir;
        neg = cmd[CMD_W-1];
        mag = neg ? (17'h10000 - {1'b0, cmd}) : {1'b0, cmd};
        if (!cfg_drive_enable)
            mag = '0;
        if (mag > {4'd0, cfg_current_limit})
            mag = {4'd0, cfg_current_limit};
        if (mag == '0) begin
            fwd_duty = '0;
            rev_duty = '0;
            left_on  = 1'b0;
            right_on = 1'b0;
            last_dir = DIR_STOP;
            push_pin_state(1'b0, 1'b1);
            return;
        end
        dir = neg ? DIR_REV : DIR_FWD;
        if (dir == last_dir) begin
            if (dir == DIR_FWD) begin
                left_on  = 1'b0;
                right_on = 1'b1;
                fwd_duty = mag[DUTY_W-1:0];
            end else begin
                right_on = 1'b0;
                left_on  = 1'b1;
                rev_duty = mag[DUTY_W-1:0];
            end
            push_pin_state(1'b0, 1'b1);
            return;
        end
        // break before make: clear, open, close, then set the duty
        dir_changes++;
        if (dir == DIR_FWD) begin
            rev_duty = '0;
            push_pin_state(1'b1, 1'b0);
            left_on = 1'b0;
            push_pin_state(1'b1, 1'b0);
            right_on = 1'b1;
            push_pin_state(1'b1, 1'b0);
            fwd_duty = mag[DUTY_W-1:0];
            push_pin_state(1'b0, 1'b1);
        end else begin
            fwd_duty = '0;
            push_pin_state(1'b1, 1'b0);
            right_on = 1'b0;
            push_pin_state(1'b1, 1'b0);
            left_on = 1'b1;
            push_pin_state(1'b1, 1'b0);
            rev_duty = mag[DUTY_W-1:0];
            push_pin_state(1'b0, 1'b1);
        end
        last_dir = dir;
    endtask

    // mostly runs of one direction up to just past the current limit, some zeros and noise
    function automatic logic [CMD_W-1:0] random_drive_command();
        int pick;
        int mag;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 20)
            return CMD_W'($urandom);
        if (run_left == 0) begin
            run_left = $urandom_range(6, 1);
            run_neg  = 1'($urandom_range(1));
        end
        run_left--;
        if (pick < 28)
            mag = $urandom_range(32768, 1);
        else if (pick < 36)
            mag = $urandom_range(3, 1);
        else
            mag = $urandom_range(int'(cfg_current_limit) + 300, 1);
        if (!run_neg && mag > 32767)
            mag = 32767;
        return run_neg ? CMD_W'(-mag) : CMD_W'(mag);
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_pin_states(i_s_axis_tdata);
                cmds_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (drive_cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= drive_cmd_queue.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long output stall, counted on its own
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // pin-state monitor
    always @(posedge i_clk) begin : pin_state_monitor
        t_pin_state want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_pin_states.size() == 0) begin
                $display("%0t: unexpected pin state, expected none actual data %h last %b",
                         $time, o_m_axis_tdata, o_m_axis_tlast);
                errors++;
            end else begin
                want = expected_pin_states.pop_front();
                check_field("forward_compare", int'(want.fwd_cmp),
                            int'(o_m_axis_tdata[12:0]));
                check_field("reverse_compare", int'(want.rev_cmp),
                            int'(o_m_axis_tdata[25:13]));
                check_field("left low enable", int'(want.left_on),
                            int'(o_m_axis_tdata[26]));
                check_field("right low enable", int'(want.right_on),
                            int'(o_m_axis_tdata[27]));
                check_field("settle_after", int'(want.settle), int'(o_m_axis_tdata[28]));
                check_field("tdata padding", 0, int'(o_m_axis_tdata[31:29]));
                check_field("last_of_run", int'(want.last), int'(o_m_axis_tlast));
                pin_states_seen++;
            end
        end
    end

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (drive_cmd_queue.size() != 0 || i_s_axis_tvalid
                   || expected_pin_states.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DRIVE_ENABLE:  cfg_drive_enable  = value[0];
            CFG_CURRENT_LIMIT: cfg_current_limit = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) drive_cmd_queue.push_back(random_drive_command());
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 53;
        // drive is disabled out of reset
        drive_cmd_queue.push_back(16'd1000);
        drive_cmd_queue.push_back(-16'sd1000);
        wait_idle();
        write_register(CFG_DRIVE_ENABLE, 13'd1);
        // limits, signs, direction flips, same-direction updates, reset limit
        drive_cmd_queue = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'hFFFE, 16'h7FFF,
                            16'h8000, 16'd4500, 16'd4501, 16'hEE6D, 16'hEE6B,
                            16'd0, 16'hFFF9, 16'd7, 16'd7, 16'd0, 16'd0,
                            16'h5555, 16'hAAAA, 16'd300, 16'hFED4};
        wait_idle();

        write_register(CFG_CURRENT_LIMIT, 13'd5000);
        queue_random(80);
        wait_idle();

        // stall the output while commands keep coming
        hold_go = 1'b1;
        queue_random(40);
        wait_idle();

        send_idle_pct = 53;
        recv_idle_pct = 20;
        write_register(CFG_CURRENT_LIMIT, 13'd0);
        queue_random(15);
        wait_idle();
        write_register(CFG_CURRENT_LIMIT, 13'd8191);
        queue_random(80);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_DRIVE_ENABLE, 13'd0);
        queue_random(20);
        wait_idle();
        write_register(CFG_DRIVE_ENABLE, 13'd1);
        write_register(CFG_CURRENT_LIMIT, 13'd1);
        queue_random(20);
        wait_idle();
        write_register(CFG_CURRENT_LIMIT, 13'($urandom_range(5000, 100)));
        queue_random(100);
        wait_idle();

        $display("covered %0d drive commands, %0d direction changes or starts, %0d pin states",
                 cmds_accepted, dir_changes, pin_states_seen);
        $display("limits 0, 1, 4500, 5000, 8191 and random, drive on and off, long output stall");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d pin states outstanding", expected_pin_states.size());
        $display("tb: failure");
        $finish;
    end

endmodule
